[sv/pdrc_pkg.sv]
// pdrc_pkg: shared types and constants for the packet deframer
// with the rotate-and-add checksum; no dependencies
package pdrc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PhaseW = 6;

  localparam logic [ByteW-1:0] HeadReset = 8'd204;
  localparam logic [ByteW-1:0] TailReset = 8'd185;

  typedef enum logic [KindW-1:0] {
    KIND_DATA     = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_TAIL_ERR = 3'd2,
    KIND_SUM_ERR  = 3'd3,
    KIND_LEN_ERR  = 3'd4
  } kind_e;

  typedef enum logic [PhaseW-1:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_ID      = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_TAIL    = 6'b010000,
    PH_CHECK   = 6'b100000
  } phase_e;

  typedef enum logic {
    REG_HEAD = 1'b0,
    REG_TAIL = 1'b1
  } reg_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ByteW-1:0] msg_id;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_pos;
    logic [ByteW-1:0] payload_count;
  } result_t;

  // rotate right by one, then add the byte, mod 256
  function automatic logic [ByteW-1:0] sum_step(logic [ByteW-1:0] sum,
                                                logic [ByteW-1:0] b);
    logic [ByteW-1:0] rot;
    rot = {sum[0], sum[ByteW-1:1]};
    return rot + b;
  endfunction

endpackage

[sv/pdrc_core.sv]
// pdrc_core: framing state machine and running checksum
// depends on pdrc_pkg
module pdrc_core
  import pdrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic [ByteW-1:0] head_byte_i,
  input  logic [ByteW-1:0] tail_byte_i,
  output result_t          res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] id_q, id_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] count;
  logic [ByteW-1:0] idx_inc;

  assign count   = len_q - 8'd1;
  assign idx_inc = idx_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    res_o   = '{valid: 1'b0, kind: KIND_DATA, msg_id: id_q, data_byte: rx_byte_i,
                byte_pos: '0, payload_count: count};
    unique case (phase_q)
      PH_LEN: begin
        len_d = rx_byte_i;
        if (rx_byte_i == '0) begin
          res_o.valid         = 1'b1;
          res_o.kind          = KIND_LEN_ERR;
          res_o.payload_count = '0;
          phase_d             = PH_HUNT;
        end else begin
          phase_d = PH_ID;
        end
      end
      PH_ID: begin
        id_d    = rx_byte_i;
        sum_d   = sum_step(sum_q, rx_byte_i);
        phase_d = (len_q == 8'd1) ? PH_TAIL : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_d          = sum_step(sum_q, rx_byte_i);
        res_o.valid    = 1'b1;
        res_o.kind     = KIND_DATA;
        res_o.byte_pos = idx_q;
        idx_d          = idx_inc;
        if (idx_inc == count) phase_d = PH_TAIL;
      end
      PH_TAIL: begin
        if (rx_byte_i != tail_byte_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_TAIL_ERR;
          phase_d     = PH_HUNT;
        end else begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_o.valid = 1'b1;
        res_o.kind  = (rx_byte_i == sum_q) ? KIND_ACCEPT : KIND_SUM_ERR;
        phase_d     = PH_HUNT;
      end
      default: begin
        if (rx_byte_i == head_byte_i) begin
          id_d    = '0;
          len_d   = '0;
          idx_d   = '0;
          sum_d   = '0;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

endmodule

[sv/packet_deframer_rotating_checksum_top.sv]
// packet_deframer_rotating_checksum_top: input register, deframer core,
// result register and configuration registers; depends on pdrc_pkg, pdrc_core
//
// channel  dir  handshake               payload
// s_axis   in   s_tvalid_i/s_tready_o   tdata[7:0] rx_byte
// m_axis   out  m_tvalid_o/m_tready_i   tdata: msg_id, data_byte, byte_pos,
//                                       payload_count; tuser: kind
// apb      in   psel/penable/pready     head_byte at 0x0, tail_byte at 0x4
//
// one item per cycle while no result is stalled; the edge that accepts an item loads the input
// register, and the edge that moves it on runs the core and loads the result register
// reset puts the deframer in head hunting and loads the default head and
// tail bytes
// a stalled result holds the input register; s_tready_o falls only then
module packet_deframer_rotating_checksum_top
  import pdrc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [ByteW-1:0]         s_tdata_i,   // rx_byte
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [4*ByteW-1:0]       m_tdata_o,   // msg_id, data_byte, byte_pos, payload_count
  output logic [KindW-1:0]         m_tuser_o,   // kind
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             advance;
  logic [ByteW-1:0] head_q, tail_q;
  result_t          res;
  result_t          out_q, out_d;
  logic             cfg_we;
  reg_e             cfg_sel;

  // configuration
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HeadReset;
      tail_q <= TailReset;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_HEAD: head_q <= pwdata[ByteW-1:0];
        REG_TAIL: tail_q <= pwdata[ByteW-1:0];
        default:  head_q <= head_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_HEAD: prdata = {{(DataW-ByteW){1'b0}}, head_q};
      REG_TAIL: prdata = {{(DataW-ByteW){1'b0}}, tail_q};
      default:  prdata = '0;
    endcase
  end

  // input register
  assign advance    = in_valid_q && (!out_q.valid || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign in_valid_d = s_tvalid_i ? 1'b1 : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) in_byte_q <= s_tdata_i;
  end

  pdrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .rx_byte_i   (in_byte_q),
    .head_byte_i (head_q),
    .tail_byte_i (tail_q),
    .res_o       (res)
  );

  // result register
  always_comb begin
    out_d = out_q;
    if (advance) begin
      out_d = res;
    end else if (m_tready_i) begin
      out_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = out_q.valid;
  assign m_tuser_o  = out_q.kind;
  assign m_tdata_o  = {out_q.payload_count, out_q.byte_pos, out_q.data_byte, out_q.msg_id};

`ifndef NO_ASSERTIONS
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tuser_o <= KIND_LEN_ERR))
    else $error("result kind out of range");

  a_pos_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == KIND_DATA) |-> (m_tdata_o[23:16] < m_tdata_o[31:24]))
    else $error("payload position beyond payload count");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("pending item lost from input register");

  a_len_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == KIND_LEN_ERR) |-> (m_tdata_o[31:24] == '0 &&
                                                   m_tdata_o[15:8] == '0))
    else $error("length error result with nonzero length");
`endif

endmodule
